// ----- design/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int MAX_TASKS = 16;
   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   // request actions
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_CREATE  = 3'd1;
   localparam logic [2:0] ACT_START   = 3'd2;
   localparam logic [2:0] ACT_YIELD   = 3'd3;
   localparam logic [2:0] ACT_SLEEP   = 3'd4;
   localparam logic [2:0] ACT_SUSPEND = 3'd5;
   localparam logic [2:0] ACT_KILL    = 3'd6;
   localparam logic [2:0] ACT_RESUME  = 3'd7;

   // response status
   localparam logic [2:0] RS_OK          = 3'd0;
   localparam logic [2:0] RS_NOT_FOUND   = 3'd1;
   localparam logic [2:0] RS_FULL        = 3'd2;
   localparam logic [2:0] RS_NO_READY    = 3'd3;
   localparam logic [2:0] RS_NOT_STARTED = 3'd4;

   // task states
   localparam logic [1:0] TS_READY = 2'd0;
   localparam logic [1:0] TS_RUN   = 2'd1;
   localparam logic [1:0] TS_SLEEP = 2'd2;
   localparam logic [1:0] TS_BLOCK = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_LATCH      = 4'd1;
   localparam logic [3:0] OP_RD_HEAD    = 4'd2;
   localparam logic [3:0] OP_RD_IDX     = 4'd3;
   localparam logic [3:0] OP_CLR_IDX    = 4'd4;
   localparam logic [3:0] OP_AGE_WR     = 4'd5;
   localparam logic [3:0] OP_CREATE     = 4'd6;
   localparam logic [3:0] OP_RUN_HEAD   = 4'd7;
   localparam logic [3:0] OP_RESUME_WR  = 4'd8;
   localparam logic [3:0] OP_CUR_ROT    = 4'd9;
   localparam logic [3:0] OP_KILL       = 4'd10;
   localparam logic [3:0] OP_ROT        = 4'd11;
   localparam logic [3:0] OP_NONE_READY = 4'd12;
   localparam logic [3:0] OP_IDX_INC    = 4'd13;

   typedef struct packed {
      logic [31:0] pid;
      logic [1:0]  st;
      logic [31:0] slp;
      logic [31:0] run;
   } task_type;

   typedef struct packed {
      logic [3:0] op;
      logic       set_st;
      logic [2:0] st;
   } cmd_type;

   typedef struct packed {
      logic [2:0] act;
      logic       cnt_zero;
      logic       cnt_full;
      logic       started;
      logic       has_cur;
      logic       rd_ready;
      logic       pid_match;
      logic       idx_last;
      logic       idx_eq_cnt;
   } sts_type;

endpackage

// ----- design/rrts_dp.sv -----
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: task ring memory, head pointer, counters, result words.
// ----------------------------------------------------------------------------
module rrts_dp (
   input  logic               clock,
   input  logic               reset,
   input  rrts_pkg::cmd_type  cmd,
   output rrts_pkg::sts_type  sts,
   input  logic [2:0]         req_action,
   input  logic [31:0]        req_sleep_ticks,
   input  logic [31:0]        req_target_pid,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_current_pid,
   output logic               rsp_switched,
   output logic [31:0]        rsp_created_pid
);
   import rrts_pkg::*;

   task_type mem [MAX_TASKS];
   task_type rd_ff;

   logic [2:0]    act_ff;
   logic [31:0]   slp_ff, tgt_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [31:0]   pidc_ff, pidc_in, cur_ff, cur_in;
   logic          started_ff, started_in, hascur_ff, hascur_in;
   logic [2:0]    st_ff, st_in;
   logic          sw_ff, sw_in;
   logic [31:0]   crt_ff, crt_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   task_type      wr_data, aged;
   logic [31:0]   pid_next;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
      if (s >= (CW+1)'(MAX_TASKS)) s = s - (CW+1)'(MAX_TASKS);
      return s[AW-1:0];
   endfunction

   always_comb begin
      aged = rd_ff;
      unique case (rd_ff.st)
         TS_BLOCK: aged.run = '0;
         TS_RUN:   if (rd_ff.run != '1) aged.run = rd_ff.run + 32'd1;
         TS_SLEEP: begin
            if (rd_ff.slp != '0) aged.slp = rd_ff.slp - 32'd1;
            if (aged.slp == '0) aged.st = TS_READY;
         end
         default: ;
      endcase
   end

   assign pid_next = (pidc_ff + 32'd1 == '0) ? 32'd1 : pidc_ff + 32'd1;

   always_comb begin
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      pidc_in    = pidc_ff;
      cur_in     = cur_ff;
      started_in = started_ff;
      hascur_in  = hascur_ff;
      st_in      = st_ff;
      sw_in      = sw_ff;
      crt_in     = crt_ff;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      wr_addr    = head_ff;
      wr_data    = rd_ff;
      unique case (cmd.op)
         OP_LATCH: begin
            st_in  = RS_OK;
            sw_in  = 1'b0;
            crt_in = '0;
         end
         OP_RD_HEAD: rd_en = 1'b1;
         OP_RD_IDX: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, idx_ff);
         end
         OP_CLR_IDX: idx_in = '0;
         OP_IDX_INC: idx_in = idx_ff + 1'b1;
         OP_AGE_WR: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff);
            wr_data = aged;
            idx_in  = idx_ff + 1'b1;
         end
         OP_CREATE: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, cnt_ff);
            wr_data = '{pid: pid_next, st: TS_READY, slp: '0, run: '0};
            pidc_in = pid_next;
            crt_in  = pid_next;
            cnt_in  = cnt_ff + 1'b1;
         end
         OP_RUN_HEAD: begin
            wr_en      = 1'b1;
            wr_data.st = TS_RUN;
            cur_in     = rd_ff.pid;
            started_in = 1'b1;
            hascur_in  = 1'b1;
            if (act_ff == ACT_TICK || act_ff == ACT_START) sw_in = 1'b1;
            else sw_in = (act_ff == ACT_KILL) || (idx_ff + 1'b1 != cnt_ff);
         end
         OP_RESUME_WR: begin
            wr_en   = (rd_ff.st == TS_BLOCK);
            wr_addr = phys(head_ff, idx_ff);
            wr_data.st = TS_READY;
         end
         OP_CUR_ROT: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, cnt_ff);
            if (act_ff == ACT_YIELD) wr_data.st = TS_READY;
            else if (act_ff == ACT_SLEEP) begin
               wr_data.st  = TS_SLEEP;
               wr_data.slp = (slp_ff == '0) ? 32'd1 : slp_ff;
            end else wr_data.st = TS_BLOCK;
            head_in = phys(head_ff, CW'(1));
         end
         OP_KILL: begin
            head_in = phys(head_ff, CW'(1));
            cnt_in  = cnt_ff - 1'b1;
         end
         OP_ROT: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, cnt_ff);
            head_in = phys(head_ff, CW'(1));
            idx_in  = idx_ff + 1'b1;
         end
         OP_NONE_READY: begin
            st_in = RS_NO_READY;
            if (act_ff != ACT_TICK) begin
               hascur_in = 1'b0;
               sw_in     = 1'b1;
            end
         end
         default: ;
      endcase
      if (cmd.set_st) st_in = cmd.st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
         pidc_ff    <= '0;
         started_ff <= 1'b0;
         hascur_ff  <= 1'b0;
      end else begin
         head_ff    <= head_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         pidc_ff    <= pidc_in;
         started_ff <= started_in;
         hascur_ff  <= hascur_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      st_ff  <= st_in;
      sw_ff  <= sw_in;
      crt_ff <= crt_in;
      if (cmd.op == OP_LATCH) begin
         act_ff <= req_action;
         slp_ff <= req_sleep_ticks;
         tgt_ff <= req_target_pid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   assign sts.act        = act_ff;
   assign sts.cnt_zero   = (cnt_ff == '0);
   assign sts.cnt_full   = (cnt_ff >= CW'(MAX_TASKS));
   assign sts.started    = started_ff;
   assign sts.has_cur    = hascur_ff;
   assign sts.rd_ready   = (rd_ff.st == TS_READY);
   assign sts.pid_match  = (rd_ff.pid == tgt_ff);
   assign sts.idx_last   = (idx_ff + 1'b1 == cnt_ff);
   assign sts.idx_eq_cnt = (idx_ff == cnt_ff);

   assign rsp_status      = st_ff;
   assign rsp_switched    = sw_ff;
   assign rsp_created_pid = crt_ff;
   assign rsp_current_pid = hascur_ff ? cur_ff : '0;

endmodule

// ----- design/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrts_ctrl
// Scheduler sequencer: steps the datapath through each request.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  rrts_pkg::sts_type  sts,
   output rrts_pkg::cmd_type  cmd
);
   import rrts_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISP     = 4'd1;
   localparam logic [3:0] S_AGE_RD   = 4'd2;
   localparam logic [3:0] S_AGE_WR   = 4'd3;
   localparam logic [3:0] S_SCH      = 4'd4;
   localparam logic [3:0] S_SCAN0    = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CHK = 4'd7;
   localparam logic [3:0] S_RUN      = 4'd8;
   localparam logic [3:0] S_RES_RD   = 4'd9;
   localparam logic [3:0] S_RES_CHK  = 4'd10;
   localparam logic [3:0] S_CUR_WR   = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: OP_NONE, set_st: 1'b0, st: RS_OK};
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.op   = OP_LATCH;
            state_in = S_DISP;
         end
         S_DISP: begin
            state_in = S_DONE;
            unique case (sts.act)
               ACT_TICK: begin
                  cmd.op   = OP_CLR_IDX;
                  state_in = sts.cnt_zero ? S_SCH : S_AGE_RD;
               end
               ACT_CREATE: begin
                  if (sts.cnt_full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = RS_FULL;
                  end else cmd.op = OP_CREATE;
               end
               ACT_START: begin
                  if (!sts.started) begin
                     if (sts.cnt_zero) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = RS_NO_READY;
                     end else begin
                        cmd.op   = OP_RD_HEAD;
                        state_in = S_RUN;
                     end
                  end
               end
               ACT_RESUME: begin
                  cmd.op = OP_CLR_IDX;
                  if (sts.cnt_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = RS_NOT_FOUND;
                  end else state_in = S_RES_RD;
               end
               default: begin
                  priority if (!sts.started) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = RS_NOT_STARTED;
                  end else if (!sts.has_cur || sts.cnt_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = RS_NO_READY;
                  end else if (sts.act == ACT_KILL) begin
                     cmd.op   = OP_KILL;
                     state_in = S_SCAN0;
                  end else begin
                     cmd.op   = OP_RD_HEAD;
                     state_in = S_CUR_WR;
                  end
               end
            endcase
         end
         S_AGE_RD: begin
            cmd.op   = OP_RD_IDX;
            state_in = S_AGE_WR;
         end
         S_AGE_WR: begin
            cmd.op   = OP_AGE_WR;
            state_in = sts.idx_last ? S_SCH : S_AGE_RD;
         end
         S_SCH: begin
            if (sts.started && !sts.has_cur) begin
               cmd.op   = OP_CLR_IDX;
               state_in = S_SCAN_RD;
            end else state_in = S_DONE;
         end
         S_SCAN0: begin
            cmd.op   = OP_CLR_IDX;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (sts.cnt_zero) begin
               cmd.op   = OP_NONE_READY;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_RD_HEAD;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            priority if (sts.rd_ready) begin
               cmd.op   = OP_RUN_HEAD;
               state_in = S_DONE;
            end else if (sts.idx_eq_cnt) begin
               cmd.op   = OP_NONE_READY;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_ROT;
               state_in = S_SCAN_RD;
            end
         end
         S_RUN: begin
            cmd.op   = OP_RUN_HEAD;
            state_in = S_DONE;
         end
         S_RES_RD: begin
            cmd.op   = OP_RD_IDX;
            state_in = S_RES_CHK;
         end
         S_RES_CHK: begin
            priority if (sts.pid_match) begin
               cmd.op   = OP_RESUME_WR;
               state_in = S_DONE;
            end else if (sts.idx_last) begin
               cmd.set_st = 1'b1;
               cmd.st     = RS_NOT_FOUND;
               state_in   = S_DONE;
            end else begin
               cmd.op   = OP_IDX_INC;
               state_in = S_RES_RD;
            end
         end
         S_CUR_WR: begin
            cmd.op   = OP_CUR_ROT;
            state_in = S_SCAN0;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

// ----- design/round_robin_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin task ring with sleep timers, run-tick counts and resume by pid.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   request   req_action, req_sleep_ticks, req_target_pid   start & !busy
//   response  rsp_status, rsp_current_pid,            rsp_valid, one cycle
//             rsp_switched, rsp_created_pid
//
// One request at a time: busy holds off new requests until the strobe.
// Create writes one entry; start reads and runs the head; resume reads and
// checks each task by pid; tick reads and ages every task in the task memory,
// and when started with no current task also scans for a ready task. Yield,
// sleep and suspend write the current task back to the tail, kill drops it;
// then both scan. The rotate-and-check loop does one read and one write per step.
// Reset is synchronous; task memory is not cleared, only head, count, index, pid counter and flags.
// Responses cannot be held off: each word shows for one cycle only.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_sleep_ticks,
   input  logic [31:0] req_target_pid,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_current_pid,
   output logic        rsp_switched,
   output logic [31:0] rsp_created_pid
);
   import rrts_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: decode the request, walk the ring, raise the strobe
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: ring memory kept as a circular buffer; rotate by copying the
   // head entry to the tail and advancing the head pointer
   rrts_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_sleep_ticks (req_sleep_ticks),
      .req_target_pid  (req_target_pid),
      .rsp_status      (rsp_status),
      .rsp_current_pid (rsp_current_pid),
      .rsp_switched    (rsp_switched),
      .rsp_created_pid (rsp_created_pid)
   );

endmodule
